### hw/rtl/can_id_activity_table_assert.svh
// Assertion macros used by the CAN identifier activity table RTL.
`ifndef CAN_ID_ACTIVITY_TABLE_ASSERT_SVH
`define CAN_ID_ACTIVITY_TABLE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define CIDAT_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("cidat assertion failed");
`define CIDAT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cidat sequence assertion failed");
`else
`define CIDAT_ASSERT(lbl, clk, rst_n, prop)
`define CIDAT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

### hw/rtl/cidat_pkg.sv
// Types, codes and helpers for the CAN identifier activity table.
package cidat_pkg;

  localparam int MAX_PAYLOAD = 8;

  typedef enum logic [1:0] {
    CMD_RECV   = 2'd0,
    CMD_LOOKUP = 2'd1,
    CMD_CLEAR  = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    STS_UPDATED  = 3'd0,
    STS_INSERTED = 3'd1,
    STS_FULL     = 3'd2,
    STS_LENGTH   = 3'd3,
    STS_HIT      = 3'd4,
    STS_MISS     = 3'd5,
    STS_CLEARED  = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_DONE
  } fsm_t;

  typedef struct packed {
    logic [28:0] key;
    logic [31:0] count;
    logic [3:0]  len;
    logic [63:0] bytes;
  } entry_t;

  typedef struct packed {
    cmd_t        cmd;
    logic [28:0] can_id;
    logic [3:0]  data_len;
    logic [63:0] payload;
  } req_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] hit_count;
    logic [3:0]  stored_len;
    logic [63:0] stored_data;
    logic [6:0]  entries_used;
  } res_t;

  function automatic logic [63:0] byte_mask(input logic [3:0] len);
    logic [63:0] m;
    m = '0;
    for (int b = 0; b < 8; b++) begin
      m[b*8 +: 8] = (len > 4'(b)) ? 8'hFF : 8'h00;
    end
    return m;
  endfunction

endpackage

### hw/rtl/cidat_ram.sv
// Generic single write port, single read port RAM with registered read data.
module cidat_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

### hw/rtl/cidat_ctrl.sv
// Sequencer: linear table search through the RAM read port, entry update and result build.
`include "can_id_activity_table_assert.svh"
module cidat_ctrl import cidat_pkg::*; #(
  parameter int MAX_ENTRIES = 64,
  localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1,
  localparam int CW = $clog2(MAX_ENTRIES + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          req_valid,
  output logic          req_ready,
  input  req_t          req,
  output logic          res_valid,
  input  logic          res_ready,
  output res_t          res,
  output logic          ram_we,
  output logic [AW-1:0] ram_waddr,
  output entry_t        ram_wdata,
  output logic [AW-1:0] ram_raddr,
  input  entry_t        ram_rdata
);

  fsm_t        state_r, state_nxt;
  cmd_t        cmd_r, cmd_nxt;
  logic [28:0] key_r, key_nxt;
  logic [3:0]  len_r, len_nxt;
  logic [63:0] data_r, data_nxt;
  logic [CW-1:0] scan_r, scan_nxt;
  logic        pend_r, pend_nxt;
  logic [AW-1:0] paddr_r, paddr_nxt;
  logic [CW-1:0] used_r, used_nxt;
  status_t     status_r, status_nxt;
  logic [31:0] hcnt_r, hcnt_nxt;
  logic [3:0]  slen_r, slen_nxt;
  logic [63:0] sdata_r, sdata_nxt;

  logic        issue;
  logic        match;
  logic [63:0] wmask;
  logic [CW+6:0] used_ext;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      used_r  <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      used_r  <= used_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r    <= cmd_nxt;
    key_r    <= key_nxt;
    len_r    <= len_nxt;
    data_r   <= data_nxt;
    scan_r   <= scan_nxt;
    paddr_r  <= paddr_nxt;
    status_r <= status_nxt;
    hcnt_r   <= hcnt_nxt;
    slen_r   <= slen_nxt;
    sdata_r  <= sdata_nxt;
  end

  assign issue = (scan_r < used_r);
  assign match = pend_r && (ram_rdata.key == key_r);
  assign wmask = byte_mask(len_r);

  always_comb begin
    state_nxt  = state_r;
    cmd_nxt    = cmd_r;
    key_nxt    = key_r;
    len_nxt    = len_r;
    data_nxt   = data_r;
    scan_nxt   = scan_r;
    pend_nxt   = 1'b0;
    paddr_nxt  = paddr_r;
    used_nxt   = used_r;
    status_nxt = status_r;
    hcnt_nxt   = hcnt_r;
    slen_nxt   = slen_r;
    sdata_nxt  = sdata_r;
    req_ready  = 1'b0;
    res_valid  = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = paddr_r;
    ram_wdata  = '0;
    ram_raddr  = scan_r[AW-1:0];

    case (state_r)
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd_nxt   = req.cmd;
          key_nxt   = req.can_id;
          len_nxt   = req.data_len;
          data_nxt  = req.payload;
          scan_nxt  = '0;
          hcnt_nxt  = '0;
          slen_nxt  = '0;
          sdata_nxt = '0;
          case (req.cmd)
            CMD_RECV: begin
              if (req.data_len > 4'(MAX_PAYLOAD)) begin
                status_nxt = STS_LENGTH;
                state_nxt  = ST_DONE;
              end else begin
                state_nxt = ST_SEARCH;
              end
            end
            CMD_LOOKUP: state_nxt = ST_SEARCH;
            CMD_CLEAR: begin
              used_nxt   = '0;
              status_nxt = STS_CLEARED;
              state_nxt  = ST_DONE;
            end
            default: state_nxt = ST_IDLE;
          endcase
        end
      end

      ST_SEARCH: begin
        pend_nxt  = issue;
        paddr_nxt = scan_r[AW-1:0];
        scan_nxt  = scan_r + CW'(1);
        if (match) begin
          pend_nxt  = 1'b0;
          state_nxt = ST_DONE;
          if (cmd_r == CMD_RECV) begin
            ram_we          = 1'b1;
            ram_waddr       = paddr_r;
            ram_wdata.key   = key_r;
            ram_wdata.count = ram_rdata.count + 32'd1;
            ram_wdata.len   = len_r;
            ram_wdata.bytes = (ram_rdata.bytes & ~wmask) | (data_r & wmask);
            status_nxt      = STS_UPDATED;
          end else begin
            status_nxt = STS_HIT;
            hcnt_nxt   = ram_rdata.count;
            slen_nxt   = ram_rdata.len;
            sdata_nxt  = ram_rdata.bytes & byte_mask(ram_rdata.len);
          end
        end else if (!issue) begin
          state_nxt = ST_DONE;
          if (cmd_r == CMD_RECV) begin
            if (used_r < CW'(MAX_ENTRIES)) begin
              ram_we          = 1'b1;
              ram_waddr       = used_r[AW-1:0];
              ram_wdata.key   = key_r;
              ram_wdata.count = 32'd1;
              ram_wdata.len   = len_r;
              ram_wdata.bytes = data_r & wmask;
              used_nxt        = used_r + CW'(1);
              status_nxt      = STS_INSERTED;
            end else begin
              status_nxt = STS_FULL;
            end
          end else begin
            status_nxt = STS_MISS;
          end
        end
      end

      ST_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  assign used_ext          = {7'd0, used_r};
  assign res.status        = status_r;
  assign res.hit_count     = hcnt_r;
  assign res.stored_len    = slen_r;
  assign res.stored_data   = sdata_r;
  assign res.entries_used  = used_ext[6:0];

  `CIDAT_ASSERT(a_used_bound, clk, rst_n, used_r <= CW'(MAX_ENTRIES))
  `CIDAT_ASSERT(a_pend_in_table, clk, rst_n, !pend_r || (CW'(paddr_r) < used_r))
  `CIDAT_ASSERT(a_we_in_search, clk, rst_n, !ram_we || (state_r == ST_SEARCH))
  `CIDAT_ASSERT_NEXT(a_done_release, clk, rst_n, (state_r == ST_DONE) && res_ready, state_r == ST_IDLE)

endmodule

### hw/rtl/can_id_activity_table.sv
// Top level: CAN identifier activity table with stream ports and result register.
//
//  channel  dir  tdata (low bit up)                          tuser
//  in_      in   can_id[28:0] data_len[32:29] payload[96:33]  command
//  out_     out  hit_count[31:0] stored_len[35:32]            status
//                stored_data[99:36] entries_used[106:100]
//
// Receive and lookup search the N entries in use at accept: the search reads one
// stored entry per cycle through the single RAM read port, and a hit ends it early.
// Clear and length drop skip the search. Command 3 is consumed without a result.
// Reset is synchronous; the table starts empty via the fill count, no sweep.
// in_tready is high only while the sequencer is idle; a held result in the
// output register does not block the next accept.
module can_id_activity_table import cidat_pkg::*; #(
  parameter int MAX_ENTRIES = 64
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [103:0] in_tdata,   // can_id, data_len, payload, zero pad
  input  logic [1:0]   in_tuser,   // command
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [111:0] out_tdata,  // hit_count, stored_len, stored_data, entries_used, pad
  output logic [2:0]   out_tuser   // status
);

  localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

  req_t          req;
  res_t          res;
  logic          res_valid;
  logic          res_ready;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  entry_t        ram_wdata;
  logic [AW-1:0] ram_raddr;
  entry_t        ram_rdata;

  logic out_vld_r, out_vld_nxt;
  res_t out_res_r, out_res_nxt;

  assign req.cmd      = cmd_t'(in_tuser);
  assign req.can_id   = in_tdata[28:0];
  assign req.data_len = in_tdata[32:29];
  assign req.payload  = in_tdata[96:33];

  cidat_ctrl #(
    .MAX_ENTRIES(MAX_ENTRIES)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .req_valid(in_tvalid),
    .req_ready(in_tready),
    .req      (req),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res      (res),
    .ram_we   (ram_we),
    .ram_waddr(ram_waddr),
    .ram_wdata(ram_wdata),
    .ram_raddr(ram_raddr),
    .ram_rdata(ram_rdata)
  );

  cidat_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(MAX_ENTRIES)
  ) u_ram (
    .clk    (clk),
    .wr_en  (ram_we),
    .wr_addr(ram_waddr),
    .wr_data(ram_wdata),
    .rd_addr(ram_raddr),
    .rd_data(ram_rdata)
  );

  assign res_ready = !out_vld_r || out_tready;

  always_comb begin
    out_vld_nxt = out_vld_r;
    out_res_nxt = out_res_r;
    if (out_vld_r && out_tready) begin
      out_vld_nxt = 1'b0;
    end
    if (res_valid && res_ready) begin
      out_vld_nxt = 1'b1;
      out_res_nxt = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
  end

  assign out_tvalid = out_vld_r;
  assign out_tuser  = out_res_r.status;
  assign out_tdata  = {5'd0, out_res_r.entries_used, out_res_r.stored_data,
                       out_res_r.stored_len, out_res_r.hit_count};

endmodule

### tb/can_id_activity_table_tb.sv
// Self-checking testbench for the CAN identifier activity table stream block.
`timescale 1ns / 1ps

module can_id_activity_table_tb import cidat_pkg::*;;

  localparam int TABLE_DEPTH = 64;
  localparam int TARGET_ITEMS = 1400;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [103:0] in_tdata;   // can_id, data_len, payload, zero pad
  logic [1:0]   in_tuser;   // command
  logic         out_tvalid;
  logic         out_tready;
  logic [111:0] out_tdata;  // hit_count, stored_len, stored_data, entries_used, pad
  logic [2:0]   out_tuser;  // status

  can_id_activity_table #(.MAX_ENTRIES(TABLE_DEPTH)) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  typedef struct {
    logic [1:0]  op;
    logic [28:0] id;
    logic [3:0]  len;
    logic [63:0] data;
    bit          typed;
    res_t        want;
  } probe_row_t;

  // shadow copy of the identifier table
  bit          id_held  [TABLE_DEPTH];
  logic [28:0] id_key   [TABLE_DEPTH];
  logic [31:0] id_frames[TABLE_DEPTH];
  logic [3:0]  id_len   [TABLE_DEPTH];
  logic [63:0] id_bytes [TABLE_DEPTH];
  int          ids_in_use;

  res_t        replies_due[$];
  probe_row_t  probe_rows[$];
  logic [28:0] id_pool[128];
  int          items_sent;
  int          fail_count;
  bit          steady;

  always #5 clk = ~clk;

  function automatic logic [63:0] len_mask(input logic [3:0] n);
    if (n >= 4'd8) return '1;
    return (64'd1 << (8 * n)) - 64'd1;
  endfunction

  function automatic int slot_of(input logic [28:0] id);
    for (int i = 0; i < TABLE_DEPTH; i++)
      if (id_held[i] && id_key[i] == id) return i;
    return -1;
  endfunction

  function automatic res_t mk_reply(input status_t st, input logic [31:0] cnt,
                                    input logic [3:0] len, input logic [63:0] data,
                                    input int used);
    res_t r;
    r.status       = st;
    r.hit_count    = cnt;
    r.stored_len   = len;
    r.stored_data  = data;
    r.entries_used = 7'(used);
    return r;
  endfunction

  // advances the shadow table; returns 0 when the command yields no result
  function automatic bit table_apply(input logic [1:0] op, input logic [28:0] id,
                                     input logic [3:0] len, input logic [63:0] data,
                                     output res_t r);
    int          slot;
    logic [63:0] m;
    r = '0;
    r.status = STS_UPDATED;
    if (op == CMD_UNUSED) return 1'b0;
    if (op == CMD_RECV) begin
      if (len > MAX_PAYLOAD) begin
        r.status = STS_LENGTH;
      end else begin
        slot = slot_of(id);
        if (slot < 0 && ids_in_use < TABLE_DEPTH)
          for (int i = TABLE_DEPTH - 1; i >= 0; i--)
            if (!id_held[i]) slot = i;
        if (slot < 0) begin
          r.status = STS_FULL;
        end else begin
          if (!id_held[slot]) begin
            id_held[slot]   = 1'b1;
            id_key[slot]    = id;
            id_frames[slot] = '0;
            id_len[slot]    = '0;
            id_bytes[slot]  = '0;
            ids_in_use++;
            r.status = STS_INSERTED;
          end
          m = len_mask(len);
          id_frames[slot] = id_frames[slot] + 32'd1;
          id_bytes[slot]  = (id_bytes[slot] & ~m) | (data & m);
          id_len[slot]    = len;
        end
      end
    end else if (op == CMD_LOOKUP) begin
      slot = slot_of(id);
      if (slot < 0) begin
        r.status = STS_MISS;
      end else begin
        r.status      = STS_HIT;
        r.hit_count   = id_frames[slot];
        r.stored_len  = id_len[slot];
        r.stored_data = id_bytes[slot] & len_mask(id_len[slot]);
      end
    end else begin
      for (int i = 0; i < TABLE_DEPTH; i++) id_held[i] = 1'b0;
      ids_in_use = 0;
      r.status = STS_CLEARED;
    end
    r.entries_used = 7'(ids_in_use);
    return 1'b1;
  endfunction

  function automatic logic [28:0] fresh_id();
    if ($urandom_range(0, 3) == 0) return 29'($urandom_range(0, 2047));
    return 29'($urandom);
  endfunction

  function automatic logic [3:0] rand_len();
    if ($urandom_range(0, 7) == 0) return 4'($urandom_range(9, 15));
    return 4'($urandom_range(0, 8));
  endfunction

  task automatic send_item(input logic [1:0] op, input logic [28:0] id,
                           input logic [3:0] len, input logic [63:0] data,
                           input bit typed, input res_t want);
    int   gap;
    res_t predicted;
    gap = steady ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {7'd0, data, len, id};
    do @(posedge clk); while (!in_tready);
    if (table_apply(op, id, len, data, predicted)) begin
      replies_due.push_back(typed ? want : predicted);
      items_sent++;
    end
  endtask

  task automatic send_plain(input logic [1:0] op, input logic [28:0] id);
    send_item(op, id, rand_len(), {$urandom, $urandom}, 1'b0, '0);
  endtask

  task automatic add_row(input logic [1:0] op, input logic [28:0] id, input logic [3:0] len,
                         input logic [63:0] data, input bit typed, input res_t want);
    probe_row_t row;
    row.op = op; row.id = id; row.len = len; row.data = data;
    row.typed = typed; row.want = want;
    probe_rows.push_back(row);
  endtask

  task automatic note_failure(input string what, input res_t want, input res_t seen);
    fail_count++;
    if (fail_count <= 10) begin
      $write("%0t %s: exp st=%0d cnt=%h len=%0d data=%h used=%0d",
             $realtime, what, want.status, want.hit_count, want.stored_len,
             want.stored_data, want.entries_used);
      $display(" | got st=%0d cnt=%h len=%0d data=%h used=%0d",
               seen.status, seen.hit_count, seen.stored_len, seen.stored_data,
               seen.entries_used);
    end
  endtask

  always @(posedge clk) begin
    res_t seen;
    res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      seen.status       = status_t'(out_tuser);
      seen.hit_count    = out_tdata[31:0];
      seen.stored_len   = out_tdata[35:32];
      seen.stored_data  = out_tdata[99:36];
      seen.entries_used = out_tdata[106:100];
      if (replies_due.size() == 0) begin
        note_failure("unexpected transaction", '0, seen);
      end else begin
        want = replies_due.pop_front();
        if (seen.status !== want.status || seen.hit_count !== want.hit_count ||
            seen.stored_len !== want.stored_len || seen.stored_data !== want.stored_data ||
            seen.entries_used !== want.entries_used)
          note_failure("mismatch", want, seen);
      end
    end
  end

  // result side back-pressure
  initial begin
    int gap;
    out_tready <= 1'b0;
    @(posedge rst_n);
    forever begin
      gap = steady ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  initial begin
    #20ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    int pool_n;
    int steps;
    int pick;
    bit first;
    clk        = 1'b0;
    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    in_tuser   <= CMD_UNUSED;
    steady     = 1'b0;
    items_sent = 0;
    fail_count = 0;
    ids_in_use = 0;
    for (int i = 0; i < TABLE_DEPTH; i++) id_held[i] = 1'b0;

    add_row(CMD_LOOKUP, 29'h0, 4'd0, 64'h0, 1, mk_reply(STS_MISS, 0, 0, 0, 0));
    add_row(CMD_RECV, 29'h0, 4'd8, '1, 1, mk_reply(STS_INSERTED, 0, 0, 0, 1));
    add_row(CMD_RECV, 29'h1FFFFFFF, 4'd0, '1, 1, mk_reply(STS_INSERTED, 0, 0, 0, 2));
    add_row(CMD_LOOKUP, 29'h0, 4'd0, 64'h0, 1, mk_reply(STS_HIT, 1, 8, '1, 2));
    add_row(CMD_LOOKUP, 29'h1FFFFFFF, 4'd15, '1, 1, mk_reply(STS_HIT, 1, 0, 0, 2));
    add_row(CMD_RECV, 29'h0, 4'd9, '1, 1, mk_reply(STS_LENGTH, 0, 0, 0, 2));
    add_row(CMD_RECV, 29'h1FFFFFFF, 4'd15, '1, 1, mk_reply(STS_LENGTH, 0, 0, 0, 2));
    add_row(CMD_RECV, 29'h0, 4'd3, 64'h1122334455667788, 1,
            mk_reply(STS_UPDATED, 0, 0, 0, 2));
    add_row(CMD_LOOKUP, 29'h0, 4'd0, 64'h0, 0, '0);
    add_row(CMD_RECV, 29'h0, 4'd8, 64'h0, 1, mk_reply(STS_UPDATED, 0, 0, 0, 2));
    add_row(CMD_LOOKUP, 29'h0, 4'd0, 64'h0, 0, '0);
    add_row(CMD_RECV, 29'h15555555, 4'd5, 64'h5555555555555555, 1,
            mk_reply(STS_INSERTED, 0, 0, 0, 3));
    add_row(CMD_RECV, 29'h0AAAAAAA, 4'd7, 64'hAAAAAAAAAAAAAAAA, 1,
            mk_reply(STS_INSERTED, 0, 0, 0, 4));
    add_row(CMD_UNUSED, 29'h15555555, 4'd8, '1, 0, '0);
    add_row(CMD_LOOKUP, 29'h15555555, 4'd0, 64'h0, 0, '0);
    add_row(CMD_LOOKUP, 29'h0AAAAAAA, 4'd0, 64'h0, 0, '0);
    add_row(CMD_LOOKUP, 29'h123, 4'd0, 64'h0, 1, mk_reply(STS_MISS, 0, 0, 0, 4));
    add_row(CMD_CLEAR, 29'h0, 4'd0, 64'h0, 1, mk_reply(STS_CLEARED, 0, 0, 0, 0));
    add_row(CMD_LOOKUP, 29'h0, 4'd0, 64'h0, 1, mk_reply(STS_MISS, 0, 0, 0, 0));
    add_row(CMD_RECV, 29'h7FF, 4'd1, 64'hFF, 1, mk_reply(STS_INSERTED, 0, 0, 0, 1));
    add_row(CMD_LOOKUP, 29'h7FF, 4'd0, 64'h0, 0, '0);
    add_row(CMD_CLEAR, 29'h7FF, 4'd0, 64'h0, 1, mk_reply(STS_CLEARED, 0, 0, 0, 0));

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    foreach (probe_rows[i])
      send_item(probe_rows[i].op, probe_rows[i].id, probe_rows[i].len,
                probe_rows[i].data, probe_rows[i].typed, probe_rows[i].want);

    // episodes over a key pool; the first one is sized to overrun the table
    first = 1'b1;
    while (items_sent < TARGET_ITEMS) begin
      steady = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 5))
        0: pool_n = 4;
        1: pool_n = 16;
        2: pool_n = 63;
        3: pool_n = 64;
        4: pool_n = 65;
        default: pool_n = 90;
      endcase
      if (first) pool_n = 90;
      for (int i = 0; i < pool_n; i++) id_pool[i] = fresh_id();
      if (first || $urandom_range(0, 1) == 1)
        for (int i = 0; i < pool_n; i++) send_plain(CMD_RECV, id_pool[i]);
      first = 1'b0;
      steps = $urandom_range(20, 120);
      for (int s = 0; s < steps; s++) begin
        pick = $urandom_range(0, 99);
        if (pick < 50)      send_plain(CMD_RECV, id_pool[$urandom_range(0, pool_n - 1)]);
        else if (pick < 85) send_plain(CMD_LOOKUP, id_pool[$urandom_range(0, pool_n - 1)]);
        else if (pick < 92) send_plain(CMD_RECV, fresh_id());
        else if (pick < 96) send_plain(CMD_LOOKUP, fresh_id());
        else if (pick < 98) send_plain(CMD_UNUSED, fresh_id());
        else                send_plain(CMD_CLEAR, fresh_id());
      end
      if ($urandom_range(0, 3) != 0) send_plain(CMD_CLEAR, fresh_id());
    end

    in_tvalid <= 1'b0;
    while (replies_due.size() > 0) @(posedge clk);
    repeat (TABLE_DEPTH + 16) @(posedge clk);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
